/* src/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared constants, types and codes for the shortest-remaining-time-first
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

  localparam int SLOTS      = 16;
  localparam int BURST_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int SLOT_FIELD_BITS  = 4;
  localparam int BURST_FIELD_BITS = 16;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef logic [SLOT_BITS-1:0]  idx_t;
  typedef logic [BURST_BITS-1:0] rem_t;
  typedef logic [TIME_BITS-1:0]  time_t;

  typedef struct packed {
    logic  rem_we;
    idx_t  rem_addr;
    rem_t  rem_data;
    logic  task_we;
    idx_t  task_addr;
    time_t stamp;
    rem_t  orig;
    logic  clr_occ;
    idx_t  clr_addr;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* src/srtf_if.sv */
// ----------------------------------------------------------------------------
// srtf_if
// Valid/ready channels for task items and scheduler results.
// ----------------------------------------------------------------------------
`default_nettype none

interface srtf_req_if;
  import srtf_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [SLOT_FIELD_BITS-1:0]  slot;
  logic [BURST_FIELD_BITS-1:0] burst;

  modport source (output valid, kind, slot, burst, input ready);
  modport sink (input valid, kind, slot, burst, output ready);
endinterface

interface srtf_rsp_if;
  import srtf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       busy_res;
  logic [SLOT_FIELD_BITS-1:0] running_slot;
  logic                       done_res;
  logic [SLOT_FIELD_BITS-1:0] done_slot;
  logic [TIME_BITS-1:0]       finish_time;
  logic [TIME_BITS-1:0]       turnaround;
  logic [TIME_BITS-1:0]       waiting;
  logic                       error;

  modport source (output valid, busy_res, running_slot, done_res, done_slot, finish_time,
                  turnaround, waiting, error, input ready);
  modport sink (input valid, busy_res, running_slot, done_res, done_slot, finish_time,
                turnaround, waiting, error, output ready);
endinterface

`default_nettype wire

/* src/srtf_table.sv */
// ----------------------------------------------------------------------------
// srtf_table
// Task table: remaining time, arrival stamp and original burst per slot,
// each with one write and one registered read, plus occupancy flags.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_table (
  input  logic                          clk,
  input  logic                          rst,
  input  srtf_pkg::tbl_wr_t             wr,
  input  srtf_pkg::idx_t                rem_raddr,
  input  srtf_pkg::idx_t                task_raddr,
  input  srtf_pkg::idx_t                set_addr,
  output srtf_pkg::rem_t                rem_rd,
  output srtf_pkg::time_t               stamp_rd,
  output srtf_pkg::rem_t                orig_rd,
  output logic [srtf_pkg::SLOTS-1:0]    occupied
);
  import srtf_pkg::*;

  rem_t  rem_mem   [SLOTS];
  time_t stamp_mem [SLOTS];
  rem_t  orig_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.rem_we) begin
      rem_mem[wr.rem_addr] <= wr.rem_data;
    end
    rem_rd <= rem_mem[rem_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.task_we) begin
      stamp_mem[wr.task_addr] <= wr.stamp;
      orig_mem[wr.task_addr]  <= wr.orig;
    end
    stamp_rd <= stamp_mem[task_raddr];
    orig_rd  <= orig_mem[task_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else begin
      if (wr.task_we) begin
        occupied[set_addr] <= 1'b1;
      end
      if (wr.clr_occ) begin
        occupied[wr.clr_addr] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/srtf_cpu_scheduler.sv */
// ----------------------------------------------------------------------------
// srtf_cpu_scheduler
// Preemptive shortest-remaining-time-first scheduler over a table of task
// slots.
// ----------------------------------------------------------------------------
// An arrival or a tick that does not finish a task is accepted and updated in
// the idle state, and its result is loaded into the output register from the
// output state once that register is free. A tick that finishes a task goes on
// through more states: it reads the arrival stamp and burst and forms
// turnaround and then waiting time, scans the slots one by one for the least
// remaining time through the single read port of the task table, dispatches
// the winner and loads the result. The input is not ready while an item is in
// progress; a result waiting in the output register does not hold up the next
// transfer on the input side.
`default_nettype none

module srtf_cpu_scheduler (
  input  logic            clk,
  input  logic            rst,
  srtf_req_if.sink        req,
  srtf_rsp_if.source      rsp
);
  import srtf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIN1 = 3'd1;
  localparam logic [2:0] S_FIN2 = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [31:0] BURST_MAX = 32'((64'd1 << BURST_BITS) - 64'd1);

  logic [2:0]       state;
  time_t            cur_time;
  idx_t             run_idx;
  rem_t             run_rem;
  logic             run_valid;

  logic             done_q;
  logic             err_q;
  idx_t             done_slot_q;
  time_t            fin_q;
  time_t            tat_q;
  time_t            wt_q;

  idx_t             scan_idx;
  rem_t             best_rem;
  idx_t             best_idx;
  logic             found;

  logic             out_valid;
  logic             out_load;
  logic             out_busy;
  logic [SLOT_FIELD_BITS-1:0] out_run_slot;
  logic             out_done;
  logic [SLOT_FIELD_BITS-1:0] out_done_slot;
  time_t            out_fin;
  time_t            out_tat;
  time_t            out_wt;
  logic             out_err;

  tbl_wr_t          wr;
  idx_t             rem_raddr;
  rem_t             rem_rd;
  time_t            stamp_rd;
  rem_t             orig_rd;
  logic [SLOTS-1:0] occupied;

  logic             accept;
  idx_t             slot_idx;
  logic             slot_ok;
  logic [31:0]      burst_wide;
  rem_t             burst_sat;
  logic             arrive_ok;
  logic             preempt;
  logic             finishing;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign out_load   = (state == S_OUT) && (!out_valid || rsp.ready);

  assign slot_idx   = idx_t'(req.slot);
  assign slot_ok    = (32'(req.slot) < 32'(SLOTS));
  assign burst_wide = 32'(req.burst);
  assign burst_sat  = rem_t'((burst_wide > BURST_MAX) ? BURST_MAX : burst_wide);
  assign arrive_ok  = (burst_sat != '0) && slot_ok && !occupied[slot_idx];
  assign preempt    = run_valid && (burst_sat < run_rem);
  assign finishing  = run_valid && (run_rem == rem_t'(1));

  always_comb begin
    wr           = '0;
    wr.task_addr = slot_idx;
    wr.stamp     = cur_time;
    wr.orig      = burst_sat;
    wr.clr_addr  = run_idx;
    if (preempt) begin
      wr.rem_addr = run_idx;
      wr.rem_data = run_rem;
    end else begin
      wr.rem_addr = slot_idx;
      wr.rem_data = burst_sat;
    end
    if (accept && (req.kind == KIND_ARRIVE) && arrive_ok) begin
      wr.rem_we  = 1'b1;
      wr.task_we = 1'b1;
    end
    if (accept && (req.kind == KIND_TICK) && finishing) begin
      wr.clr_occ = 1'b1;
    end
  end

  assign rem_raddr = (state == S_SCAN) ? idx_t'(scan_idx + idx_t'(1)) : '0;

  srtf_table u_table (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .rem_raddr  (rem_raddr),
    .task_raddr (run_idx),
    .set_addr   (slot_idx),
    .rem_rd     (rem_rd),
    .stamp_rd   (stamp_rd),
    .orig_rd    (orig_rd),
    .occupied   (occupied)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_time  <= '0;
      run_idx   <= '0;
      run_rem   <= '0;
      run_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tat_q <= '0;
            wt_q  <= '0;
            if (req.kind == KIND_ARRIVE) begin
              done_q      <= 1'b0;
              done_slot_q <= '0;
              fin_q       <= '0;
              err_q       <= !arrive_ok;
              state       <= S_OUT;
              if (arrive_ok && (!run_valid || preempt)) begin
                run_valid <= 1'b1;
                run_idx   <= slot_idx;
                run_rem   <= burst_sat;
              end
            end else begin
              err_q    <= 1'b0;
              cur_time <= cur_time + time_t'(1);
              if (run_valid) begin
                run_rem <= run_rem - rem_t'(1);
              end
              if (finishing) begin
                done_q      <= 1'b1;
                done_slot_q <= run_idx;
                fin_q       <= cur_time + time_t'(1);
                state       <= S_FIN1;
              end else begin
                done_q      <= 1'b0;
                done_slot_q <= '0;
                fin_q       <= '0;
                state       <= S_OUT;
              end
            end
          end
        end
        S_FIN1: begin
          tat_q <= fin_q - stamp_rd;
          state <= S_FIN2;
        end
        S_FIN2: begin
          wt_q     <= tat_q - time_t'(orig_rd);
          scan_idx <= '0;
          found    <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (occupied[scan_idx] && (!found || (rem_rd < best_rem))) begin
            found    <= 1'b1;
            best_rem <= rem_rd;
            best_idx <= scan_idx;
          end
          if (scan_idx == idx_t'(SLOTS - 1)) begin
            state <= S_PICK;
          end else begin
            scan_idx <= scan_idx + idx_t'(1);
          end
        end
        S_PICK: begin
          run_valid <= found;
          run_idx   <= found ? best_idx : '0;
          run_rem   <= found ? best_rem : '0;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_busy      <= run_valid;
      out_run_slot  <= run_valid ? SLOT_FIELD_BITS'(run_idx) : '0;
      out_done      <= done_q;
      out_done_slot <= SLOT_FIELD_BITS'(done_slot_q);
      out_fin       <= fin_q;
      out_tat       <= tat_q;
      out_wt        <= wt_q;
      out_err       <= err_q;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.busy_res     = out_busy;
  assign rsp.running_slot = out_run_slot;
  assign rsp.done_res     = out_done;
  assign rsp.done_slot    = out_done_slot;
  assign rsp.finish_time  = out_fin;
  assign rsp.turnaround   = out_tat;
  assign rsp.waiting      = out_wt;
  assign rsp.error        = out_err;

endmodule

`default_nettype wire

/* src/srtf_checker.sv */
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks on the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  req_valid,
  input logic                                  req_ready,
  input logic                                  rsp_valid,
  input logic                                  rsp_ready,
  input logic                                  busy_res,
  input logic [srtf_pkg::SLOT_FIELD_BITS-1:0]  running_slot,
  input logic                                  done_res,
  input logic [srtf_pkg::SLOT_FIELD_BITS-1:0]  done_slot,
  input logic [srtf_pkg::TIME_BITS-1:0]        finish_time,
  input logic [srtf_pkg::TIME_BITS-1:0]        turnaround,
  input logic [srtf_pkg::TIME_BITS-1:0]        waiting,
  input logic                                  error
);
  import srtf_pkg::*;

  // A result offered and not taken is still offered in the next cycle.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before transfer");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input ready in the cycle after a transfer");

  a_err_no_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> !done_res)
    else $error("refused arrival reports a finished task");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !done_res |->
      (done_slot == '0) && (finish_time == '0) && (turnaround == '0) && (waiting == '0))
    else $error("finish fields not zero without a finished task");

  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !busy_res |-> (running_slot == '0))
    else $error("running slot not zero while idle");

endmodule

bind srtf_cpu_scheduler srtf_checker u_srtf_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .busy_res     (rsp.busy_res),
  .running_slot (rsp.running_slot),
  .done_res     (rsp.done_res),
  .done_slot    (rsp.done_slot),
  .finish_time  (rsp.finish_time),
  .turnaround   (rsp.turnaround),
  .waiting      (rsp.waiting),
  .error        (rsp.error)
);

`default_nettype wire
